/* hdl/nlee_pkg.sv */
// Package for the neuromodulator level and effects engine.
// Holds command codes, state machine type, datapath command struct and reset constants.
// No dependencies.
package nlee_pkg;

   localparam int unsigned LEVEL_W   = 17;
   localparam int unsigned WEIGHT_W  = 18;
   localparam int unsigned DATA_W    = 32;
   localparam int unsigned EXPLORE_W = 19;
   localparam int unsigned COLUMNS_DEFAULT = 64;
   localparam int unsigned COL_IN_W  = 6;

   localparam logic [LEVEL_W-1:0] LEVEL_ONE  = 17'd65536;
   localparam logic [LEVEL_W-1:0] LEVEL_HALF = 17'd32768;

   localparam logic [WEIGHT_W-1:0] RST_DA_GAIN     = 18'd19661;
   localparam logic [WEIGHT_W-1:0] RST_NE_GAIN     = 18'd26214;
   localparam logic [WEIGHT_W-1:0] RST_ACH_INHIBIT = 18'd22938;
   localparam logic [WEIGHT_W-1:0] RST_SERO_INHIBIT = 18'd26214;
   localparam logic [WEIGHT_W-1:0] RST_ACH_SNR     = 18'd98304;
   localparam logic [WEIGHT_W-1:0] RST_NE_EXPLORE  = 18'd19661;
   localparam logic [LEVEL_W-1:0]  RST_GATE_THRESH = 17'd32768;
   localparam logic [WEIGHT_W-1:0] RST_DA_LEARN    = 18'd32768;

   typedef enum logic [2:0] {
      CMD_SET       = 3'd0,
      CMD_RELEASE   = 3'd1,
      CMD_READ      = 3'd2,
      CMD_COL_WRITE = 3'd3,
      CMD_COL_READ  = 3'd4,
      CMD_DECAY     = 3'd5,
      CMD_APPLY     = 3'd6,
      CMD_RESET     = 3'd7
   } command_type;

   typedef enum logic [2:0] {
      REG_DA_GAIN      = 3'd0,
      REG_NE_GAIN      = 3'd1,
      REG_ACH_INHIBIT  = 3'd2,
      REG_SERO_INHIBIT = 3'd3,
      REG_ACH_SNR      = 3'd4,
      REG_NE_EXPLORE   = 3'd5,
      REG_GATE_THRESH  = 3'd6,
      REG_DA_LEARN     = 3'd7
   } reg_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LEVEL,    // single-level commands, column read issue
      ST_COLRD,    // column read data returns
      ST_SWEEP_RD, // column sweep: read issue
      ST_SWEEP_WR, // column sweep: scale and write back
      ST_FACTORS,  // weighted products
      ST_SUMS,     // factor sums
      ST_SCALE,    // base times factor, one per cycle
      ST_DONE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;         // capture request
      logic do_level;     // execute single-level command
      logic col_issue;    // issue column memory read / write
      logic sweep_start;  // clear sweep index
      logic sweep_rd;     // read column at sweep index
      logic sweep_wr;     // write decayed or reset column value, advance index
      logic mul_factors;
      logic sum_factors;
      logic scale_step;   // one scale product
      logic scale_start;
      logic finish;       // assemble response
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      command_type cmd;
      logic        sweep_last;
      logic        scale_last;
      logic        decay_ok;
      logic        init_busy;   // column clearing pass after reset
   } dp_status_type;

endpackage

/* hdl/nlee_ctrl.sv */
// Controller state machine of the neuromodulator engine.
// Depends on nlee_pkg; drives datapath commands and the handshake.
module nlee_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  nlee_pkg::dp_status_type status,
   output nlee_pkg::dp_cmd_type    cmd
);

   nlee_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   // a new request is taken when idle and the column clearing pass is over
   logic accept;
   assign req_stall = !(state_ff == nlee_pkg::ST_IDLE) || status.init_busy;
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         nlee_pkg::ST_IDLE: if (accept) state_in = nlee_pkg::ST_LEVEL;
         nlee_pkg::ST_LEVEL: begin
            unique case (status.cmd)
               nlee_pkg::CMD_COL_READ: state_in = nlee_pkg::ST_COLRD;
               nlee_pkg::CMD_DECAY:
                  state_in = status.decay_ok ? nlee_pkg::ST_SWEEP_RD : nlee_pkg::ST_DONE;
               nlee_pkg::CMD_RESET: state_in = nlee_pkg::ST_SWEEP_RD;
               nlee_pkg::CMD_APPLY: state_in = nlee_pkg::ST_FACTORS;
               default: state_in = nlee_pkg::ST_DONE;
            endcase
         end
         nlee_pkg::ST_COLRD: state_in = nlee_pkg::ST_DONE;
         nlee_pkg::ST_SWEEP_RD: state_in = nlee_pkg::ST_SWEEP_WR;
         nlee_pkg::ST_SWEEP_WR:
            state_in = status.sweep_last ? nlee_pkg::ST_DONE : nlee_pkg::ST_SWEEP_RD;
         nlee_pkg::ST_FACTORS: state_in = nlee_pkg::ST_SUMS;
         nlee_pkg::ST_SUMS: state_in = nlee_pkg::ST_SCALE;
         nlee_pkg::ST_SCALE:
            if (status.scale_last) state_in = nlee_pkg::ST_DONE;
         nlee_pkg::ST_DONE:
            if (!rsp_valid_ff || !rsp_stall) state_in = nlee_pkg::ST_IDLE;
         default: state_in = nlee_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         nlee_pkg::ST_IDLE: cmd.load = accept;
         nlee_pkg::ST_LEVEL: begin
            cmd.do_level    = 1'b1;
            cmd.col_issue   = 1'b1;
            cmd.sweep_start = 1'b1;
         end
         nlee_pkg::ST_SWEEP_RD: cmd.sweep_rd = 1'b1;
         nlee_pkg::ST_SWEEP_WR: cmd.sweep_wr = 1'b1;
         nlee_pkg::ST_FACTORS: cmd.mul_factors = 1'b1;
         nlee_pkg::ST_SUMS: begin
            cmd.sum_factors = 1'b1;
            cmd.scale_start = 1'b1;
         end
         nlee_pkg::ST_SCALE: cmd.scale_step = 1'b1;
         nlee_pkg::ST_DONE: cmd.finish = !rsp_valid_ff || !rsp_stall;
         default: cmd = '0;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      if (cmd.finish) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= nlee_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_finish_from_done: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> $past(state_ff) != nlee_pkg::ST_IDLE)
      else $error("finish without a request in flight");
   a_rsp_after_finish: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid)
      else $error("response not raised after finish");
   a_idle_after_done: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> state_ff == nlee_pkg::ST_IDLE)
      else $error("controller did not return to idle");

endmodule

/* hdl/nlee_datapath.sv */
// Datapath of the neuromodulator engine: levels, column memory, multiplier, result register.
// Depends on nlee_pkg; sequenced by nlee_ctrl.
module nlee_datapath #(
   parameter int unsigned COLUMNS = nlee_pkg::COLUMNS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  nlee_pkg::dp_cmd_type    cmd,
   output nlee_pkg::dp_status_type status,
   input  logic [2:0]              req_command,
   input  logic [1:0]              req_modulator,
   input  logic [5:0]              req_column,
   input  logic signed [31:0]      req_operand_value,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [2:0]              csr_index,
   input  logic [31:0]             csr_data,
   output logic                    rsp_status,
   output logic [16:0]             rsp_level_out,
   output logic signed [31:0]      rsp_gain_out,
   output logic signed [31:0]      rsp_inhibition_out,
   output logic signed [31:0]      rsp_snr_out,
   output logic signed [31:0]      rsp_learn_rate_out,
   output logic signed [31:0]      rsp_gated_rate_out,
   output logic [18:0]             rsp_explore_factor,
   output logic                    rsp_gate_open
);

   localparam int unsigned AW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
   localparam int unsigned CW = AW + 1;  // holds COLUMNS itself

   // configuration
   logic [17:0] w_ff [8];
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         w_ff[nlee_pkg::REG_DA_GAIN]      <= nlee_pkg::RST_DA_GAIN;
         w_ff[nlee_pkg::REG_NE_GAIN]      <= nlee_pkg::RST_NE_GAIN;
         w_ff[nlee_pkg::REG_ACH_INHIBIT]  <= nlee_pkg::RST_ACH_INHIBIT;
         w_ff[nlee_pkg::REG_SERO_INHIBIT] <= nlee_pkg::RST_SERO_INHIBIT;
         w_ff[nlee_pkg::REG_ACH_SNR]      <= nlee_pkg::RST_ACH_SNR;
         w_ff[nlee_pkg::REG_NE_EXPLORE]   <= nlee_pkg::RST_NE_EXPLORE;
         w_ff[nlee_pkg::REG_GATE_THRESH]  <= {1'b0, nlee_pkg::RST_GATE_THRESH};
         w_ff[nlee_pkg::REG_DA_LEARN]     <= nlee_pkg::RST_DA_LEARN;
      end else if (csr_valid) begin
         if (csr_index == nlee_pkg::REG_GATE_THRESH)
            w_ff[csr_index] <= {1'b0, csr_data[16:0]};
         else
            w_ff[csr_index] <= csr_data[17:0];
      end
   end

   // request capture
   nlee_pkg::command_type cmd_ff;
   logic [1:0]         mod_ff;
   logic [5:0]         col_ff;
   logic signed [31:0] opv_ff;
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff <= nlee_pkg::command_type'(req_command);
         mod_ff <= req_modulator;
         col_ff <= req_column;
         opv_ff <= req_operand_value;
      end
   end

   function automatic logic [16:0] clamp_level(input logic signed [33:0] v);
      if (v < 0) return 17'd0;
      if (v > 34'sd65536) return nlee_pkg::LEVEL_ONE;
      return v[16:0];
   endfunction

   localparam int unsigned COL_IN_W_L = nlee_pkg::COL_IN_W;
   logic col_ok;
   logic decay_ok;
   assign col_ok   = {{(32-COL_IN_W_L){1'b0}}, col_ff} < 32'(COLUMNS);
   assign decay_ok = (opv_ff >= 0) && (opv_ff <= 32'sd65536);

   // column memory, filled with 0.5 by a clearing pass over every column after reset
   logic [16:0] mem [COLUMNS];
   logic [16:0] mem_rd_ff;
   logic [CW-1:0] idx_ff;
   logic [16:0] sweep_val;
   logic        mem_we;
   logic [AW-1:0] mem_wa;
   logic [16:0] mem_wd;
   logic [AW-1:0] mem_ra;
   logic        init_ff;   // clear pass after reset still pending

   assign status.sweep_last = idx_ff == CW'(COLUMNS - 1);
   assign status.decay_ok   = decay_ok;
   assign status.init_busy  = init_ff;

   // multiplier: 17 x 17 unsigned for decay
   logic [33:0] dprod;
   assign dprod = mem_rd_ff * opv_ff[16:0];
   assign sweep_val = (cmd_ff == nlee_pkg::CMD_DECAY) ? dprod[32:16] : nlee_pkg::LEVEL_HALF;

   always_comb begin
      mem_we = 1'b0;
      mem_wa = AW'(col_ff);
      mem_wd = clamp_level(34'(opv_ff));
      mem_ra = cmd.sweep_rd ? idx_ff[AW-1:0] : AW'(col_ff);
      if (cmd.col_issue && cmd_ff == nlee_pkg::CMD_COL_WRITE && col_ok) mem_we = 1'b1;
      if (cmd.sweep_wr) begin
         mem_we = 1'b1;
         mem_wa = idx_ff[AW-1:0];
         mem_wd = sweep_val;
      end
      if (init_ff) begin
         mem_we = 1'b1;
         mem_wa = idx_ff[AW-1:0];
         mem_wd = nlee_pkg::LEVEL_HALF;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      mem_rd_ff <= mem[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) idx_ff <= '0;
      else if (cmd.sweep_start) idx_ff <= '0;
      else if ((cmd.sweep_wr || init_ff) && !status.sweep_last) idx_ff <= idx_ff + 1'b1;
   end

   // input is held off until every column entry has been written once
   always_ff @(posedge clock) begin
      if (reset) init_ff <= 1'b1;
      else if (init_ff && status.sweep_last) init_ff <= 1'b0;
   end

   // modulator levels
   logic [16:0] lvl_ff [4];
   logic [16:0] rel_sum;
   logic [33:0] lprod [4];
   assign rel_sum = clamp_level(34'(lvl_ff[mod_ff]) + 34'(opv_ff));
   always_comb for (int i = 0; i < 4; i++) lprod[i] = lvl_ff[i] * opv_ff[16:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) lvl_ff[i] <= nlee_pkg::LEVEL_HALF;
      end else if (cmd.do_level) begin
         unique case (cmd_ff)
            nlee_pkg::CMD_SET: lvl_ff[mod_ff] <= clamp_level(34'(opv_ff));
            nlee_pkg::CMD_RELEASE: if (opv_ff >= 0) lvl_ff[mod_ff] <= rel_sum;
            nlee_pkg::CMD_DECAY:
               if (decay_ok) for (int i = 0; i < 4; i++) lvl_ff[i] <= lprod[i][32:16];
            nlee_pkg::CMD_RESET: for (int i = 0; i < 4; i++) lvl_ff[i] <= nlee_pkg::LEVEL_HALF;
            default: ;
         endcase
      end
   end

   // apply: weighted products then sums
   logic [17:0] wp_ff [6];
   logic signed [20:0] f_ff [4]; // gain, inhib, snr, learn
   logic [18:0] explore_ff;
   logic        gate_ff;
   logic [1:0]  sidx_ff;
   logic signed [31:0] res_ff [4];
   logic signed [52:0] sprod;
   logic signed [36:0] sq;
   logic signed [31:0] ssat;

   always_ff @(posedge clock) begin
      if (cmd.mul_factors) begin
         wp_ff[0] <= 18'((35'(lvl_ff[1]) * w_ff[nlee_pkg::REG_DA_GAIN]) >> 16);
         wp_ff[1] <= 18'((35'(lvl_ff[2]) * w_ff[nlee_pkg::REG_NE_GAIN]) >> 16);
         wp_ff[2] <= 18'((35'(lvl_ff[0]) * w_ff[nlee_pkg::REG_ACH_INHIBIT]) >> 16);
         wp_ff[3] <= 18'((35'(lvl_ff[3]) * w_ff[nlee_pkg::REG_SERO_INHIBIT]) >> 16);
         wp_ff[4] <= 18'((35'(lvl_ff[0]) * w_ff[nlee_pkg::REG_ACH_SNR]) >> 16);
         wp_ff[5] <= 18'((35'(lvl_ff[1]) * w_ff[nlee_pkg::REG_DA_LEARN]) >> 16);
         explore_ff <= 19'(20'd65536 + 20'((35'(lvl_ff[2]) * w_ff[nlee_pkg::REG_NE_EXPLORE]) >> 16));
         gate_ff <= {1'b0, lvl_ff[0]} >= w_ff[nlee_pkg::REG_GATE_THRESH];
      end
      if (cmd.sum_factors) begin
         f_ff[0] <= 21'sd65536 + $signed({3'b0, wp_ff[0]}) + $signed({3'b0, wp_ff[1]});
         f_ff[1] <= 21'sd65536 - $signed({3'b0, wp_ff[2]}) + $signed({3'b0, wp_ff[3]});
         f_ff[2] <= 21'sd65536 + $signed({3'b0, wp_ff[4]});
         f_ff[3] <= 21'sd65536 + $signed({3'b0, wp_ff[5]});
      end
   end

   // one 32x21 product per cycle; arithmetic shift floors
   assign sprod = 53'(opv_ff) * 53'(f_ff[sidx_ff]);
   assign sq    = sprod[52:16];
   assign ssat  = (sq > 37'sd2147483647) ? 32'sh7fffffff :
                  (sq < -37'sd2147483648) ? 32'sh80000000 : sq[31:0];
   assign status.scale_last = sidx_ff == 2'd3;
   assign status.cmd = cmd_ff;

   always_ff @(posedge clock) begin
      if (cmd.scale_start) sidx_ff <= 2'd0;
      else if (cmd.scale_step) begin
         res_ff[sidx_ff] <= ssat;
         sidx_ff <= sidx_ff + 2'd1;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_status <= 1'b0;
         rsp_level_out <= '0;
         rsp_gain_out <= '0;
         rsp_inhibition_out <= '0;
         rsp_snr_out <= '0;
         rsp_learn_rate_out <= '0;
         rsp_gated_rate_out <= '0;
         rsp_explore_factor <= '0;
         rsp_gate_open <= 1'b0;
         unique case (cmd_ff)
            nlee_pkg::CMD_SET, nlee_pkg::CMD_READ: rsp_level_out <= lvl_ff[mod_ff];
            nlee_pkg::CMD_RELEASE: begin
               rsp_status <= opv_ff < 0;
               rsp_level_out <= lvl_ff[mod_ff];
            end
            nlee_pkg::CMD_COL_WRITE: begin
               rsp_status <= !col_ok;
               rsp_level_out <= col_ok ? clamp_level(34'(opv_ff)) : 17'd0;
            end
            nlee_pkg::CMD_COL_READ: begin
               rsp_status <= !col_ok;
               rsp_level_out <= col_ok ? mem_rd_ff : 17'd0;
            end
            nlee_pkg::CMD_DECAY: rsp_status <= !decay_ok;
            nlee_pkg::CMD_APPLY: begin
               rsp_gain_out <= res_ff[0];
               rsp_inhibition_out <= res_ff[1];
               rsp_snr_out <= res_ff[2];
               rsp_learn_rate_out <= res_ff[3];
               rsp_gated_rate_out <= gate_ff ? res_ff[3] : 32'sd0;
               rsp_explore_factor <= explore_ff;
               rsp_gate_open <= gate_ff;
            end
            default: ;
         endcase
      end
   end

   a_gate_gated: assert property (@(posedge clock) disable iff (reset)
      $past(cmd.finish) && !rsp_gate_open |-> rsp_gated_rate_out == 0)
      else $error("gated rate nonzero with gate closed");
   a_level_range: assert property (@(posedge clock) disable iff (reset)
      lvl_ff[0] <= nlee_pkg::LEVEL_ONE && lvl_ff[1] <= nlee_pkg::LEVEL_ONE)
      else $error("level above one");
   a_sweep_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.sweep_wr |-> idx_ff < CW'(COLUMNS))
      else $error("sweep index out of range");

endmodule

/* hdl/neuromodulator_level_effects_engine.sv */
// Top level of the neuromodulator level and effects engine; uses nlee_pkg, nlee_ctrl, nlee_datapath.
// Sequencing: apply runs a weighted-product stage and a sum stage, then four scale products on
// one shared multiplier; decay and reset sweep every column with a read and a write-back.
// Throughput: one request at a time; the next can be taken in the same cycle the response is raised,
// but a finished request waits while an earlier response is still stalled.
// Reset: synchronous; levels 0.5, weights to defaults, then a clearing pass fills every column with 0.5.
module neuromodulator_level_effects_engine #(
   parameter int unsigned COLUMNS = nlee_pkg::COLUMNS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_command,
   input  logic [1:0]         req_modulator,
   input  logic [5:0]         req_column,
   input  logic signed [31:0] req_operand_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_status,
   output logic [16:0]        rsp_level_out,
   output logic signed [31:0] rsp_gain_out,
   output logic signed [31:0] rsp_inhibition_out,
   output logic signed [31:0] rsp_snr_out,
   output logic signed [31:0] rsp_learn_rate_out,
   output logic signed [31:0] rsp_gated_rate_out,
   output logic [18:0]        rsp_explore_factor,
   output logic               rsp_gate_open,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_data
);

   nlee_pkg::dp_cmd_type    cmd;
   nlee_pkg::dp_status_type status;

   nlee_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
      .status, .cmd
   );

   nlee_datapath #(.COLUMNS(COLUMNS)) u_dp (
      .clock, .reset, .cmd, .status,
      .req_command, .req_modulator, .req_column, .req_operand_value,
      .csr_valid, .csr_ready, .csr_index, .csr_data,
      .rsp_status, .rsp_level_out, .rsp_gain_out, .rsp_inhibition_out, .rsp_snr_out,
      .rsp_learn_rate_out, .rsp_gated_rate_out, .rsp_explore_factor, .rsp_gate_open
   );

endmodule
